// ----- rtl/gscc_pkg.sv -----
// Shared types and constants for the grid square cover checker.
// Used by the line chain, its cells, the result queue and the top level.
package gscc_pkg;

   // Widest row that the line chain can hold.
   localparam int MAX_WIDTH = 1024;

   // Column counter width and effective row width (which must hold MAX_WIDTH itself).
   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int EW_BITS  = COL_BITS + 1;

   // Width of the row width register as written over the CSR port.
   localparam int CFG_BITS = 11;

   // Reset value of the row width register.
   localparam logic [CFG_BITS-1:0] WIDTH_RESET = CFG_BITS'(MAX_WIDTH);

   // The chain delays a column entry by one row less one transaction.
   localparam int CHAIN_LEN = MAX_WIDTH - 1;

   // One column entry of the row above: its free bit and its covered mark.
   typedef struct packed {
      logic is_free;
      logic covered;
   } line_entry_type;

   // Control that the scan logic hands to the line chain.
   typedef struct packed {
      logic                shift;
      logic [COL_BITS-1:0] entry;
   } chain_ctrl_type;

   // Occupancy of the two-slot result queue.
   typedef logic [1:0] queue_count_type;

endpackage

// ----- rtl/gscc_cell.sv -----
// One stage of the line chain: holds the entry of a single column.
// Depends on gscc_pkg for the entry type.
module gscc_cell (
   input  logic                    clock,
   input  logic                    shift,
   input  logic                    is_entry,
   input  gscc_pkg::line_entry_type ins_data,
   input  gscc_pkg::line_entry_type prev_data,
   output gscc_pkg::line_entry_type cell_data
);

   gscc_pkg::line_entry_type entry_ff;
   gscc_pkg::line_entry_type entry_in;

   // Take the new entry at the insertion point, else the neighbor's entry.
   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = is_entry ? ins_data : prev_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign cell_data = entry_ff;

endmodule

// ----- rtl/gscc_line_chain.sv -----
// Variable length line buffer built as a row of gscc_cell stages.
// Depends on gscc_pkg and gscc_cell.
module gscc_line_chain (
   input  logic                     clock,
   input  gscc_pkg::chain_ctrl_type ctrl,
   input  gscc_pkg::line_entry_type ins_data,
   output gscc_pkg::line_entry_type tap_data
);

   gscc_pkg::line_entry_type stage_data [gscc_pkg::CHAIN_LEN];

   // Entries enter at the stage chosen by the row width and leave at the far end.
   for (genvar i = 0; i < gscc_pkg::CHAIN_LEN; i++) begin : g_stage
      gscc_pkg::line_entry_type prev_data;
      logic                     is_entry;

      if (i == 0) begin : g_head
         assign prev_data = ins_data;
      end else begin : g_body
         assign prev_data = stage_data[i-1];
      end

      assign is_entry = (ctrl.entry == gscc_pkg::COL_BITS'(i));

      gscc_cell u_cell (
         .clock     (clock),
         .shift     (ctrl.shift),
         .is_entry  (is_entry),
         .ins_data  (ins_data),
         .prev_data (prev_data),
         .cell_data (stage_data[i])
      );
   end

   assign tap_data = stage_data[gscc_pkg::CHAIN_LEN-1];

endmodule

// ----- rtl/gscc_rsp_queue.sv -----
// Two-slot result queue between the scan logic and the response channel.
// Depends on gscc_pkg for the occupancy type.
module gscc_rsp_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_data,
   output logic full,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_all_covered
);

   gscc_pkg::queue_count_type count_ff, count_in;
   logic                      head_ff, head_in;
   logic                      tail_ff, tail_in;
   logic                      pop;

   assign pop = (count_ff != 2'd0) && !rsp_stall;

   // Head slot feeds the port; the second slot backs it up while it stalls.
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full            = (count_ff == 2'd2);
   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_all_covered = head_ff;

endmodule

// ----- rtl/grid_square_cover_check_unit.sv -----
// Top level of the grid square cover checker: scan logic, line chain, result queue.
// Depends on gscc_pkg, gscc_line_chain and gscc_rsp_queue.
//
// Usage: cells of a binary grid arrive on the req_ channel in raster order, one
// transaction per cell (req_blocked high for a blocked cell), and req_last_in_frame
// marks the final cell of a grid. For each grid the block answers with one rsp_
// transaction whose rsp_all_covered is high when every free cell lies in a 2x2
// window of four free cells. The row width is written over the csr_ channel
// (csr_ready is always high) while no grid is in flight; zero acts as one and
// values above 1024 act as 1024.
// Throughput is one cell per clock while req_stall is low. The verdict enters the
// result queue when the transaction that carries the last cell is accepted. The row
// above is held in a chain of 1023 column stages that shifts once per accepted cell.
// Reset clears the frame state and the result queue and sets the width to 1024;
// no clearing pass follows, so cells are accepted from the first cycle after it.
// When the receiver stalls, up to two verdicts wait in the result queue; req_stall
// rises only while both slots are full.
module grid_square_cover_check_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_blocked,
   input  logic                          req_last_in_frame,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_all_covered,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gscc_pkg::CFG_BITS-1:0] csr_grid_width
);

   // Width register.
   logic [gscc_pkg::CFG_BITS-1:0] width_ff, width_in;

   // Frame state.
   logic [gscc_pkg::COL_BITS-1:0] column_ff, column_in;
   logic                          first_row_ff, first_row_in;
   logic                          failed_ff, failed_in;
   logic                          pend_free_ff, pend_free_in;
   logic                          pend_cov_ff, pend_cov_in;
   logic                          up_left_free_ff, up_left_free_in;
   logic                          up_left_cov_ff, up_left_cov_in;
   logic                          cur_last_valid_ff, cur_last_valid_in;
   logic [gscc_pkg::COL_BITS-1:0] cur_last_idx_ff, cur_last_idx_in;
   logic                          prev_last_valid_ff, prev_last_valid_in;
   logic [gscc_pkg::COL_BITS-1:0] prev_last_idx_ff, prev_last_idx_in;

   // Step logic.
   logic [gscc_pkg::EW_BITS-1:0]  eff_width;
   logic [gscc_pkg::COL_BITS-1:0] last_col;
   logic [gscc_pkg::COL_BITS-1:0] col;
   logic                          accept;
   logic                          free_now;
   logic                          col_nz;
   logic                          at_end;
   logic                          window;
   logic                          up_free;
   logic                          up_cov_new;
   logic                          fail_step;
   logic                          failed_new;
   logic                          left_uncov;
   logic                          cur_last_valid_new;
   logic [gscc_pkg::COL_BITS-1:0] cur_last_idx_new;
   logic                          here_uncov;
   logic                          tail_fail;
   logic                          verdict_fail;
   logic                          queue_full;

   gscc_pkg::chain_ctrl_type      chain_ctrl;
   gscc_pkg::line_entry_type      ins_data;
   gscc_pkg::line_entry_type      tap_data;
   gscc_pkg::line_entry_type      up_data;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Width register write.
   always_comb begin
      width_in = width_ff;
      if (csr_valid) begin
         width_in = csr_grid_width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= gscc_pkg::WIDTH_RESET;
      end else begin
         width_ff <= width_in;
      end
   end

   // Effective width: zero acts as one, large values saturate.
   always_comb begin
      if (width_ff == '0) begin
         eff_width = gscc_pkg::EW_BITS'(1);
      end else if (32'(width_ff) > 32'(gscc_pkg::MAX_WIDTH)) begin
         eff_width = gscc_pkg::EW_BITS'(gscc_pkg::MAX_WIDTH);
      end else begin
         eff_width = gscc_pkg::EW_BITS'(width_ff);
      end
   end

   assign last_col = gscc_pkg::COL_BITS'(eff_width - gscc_pkg::EW_BITS'(1));
   assign col      = ({1'b0, column_ff} >= eff_width) ? last_col : column_ff;

   // Line chain: the held cell enters, the row above leaves one row later.
   assign chain_ctrl.shift = accept;
   assign chain_ctrl.entry = gscc_pkg::COL_BITS'(
      gscc_pkg::EW_BITS'(gscc_pkg::MAX_WIDTH) - eff_width);

   assign ins_data.is_free = pend_free_ff;
   assign ins_data.covered = pend_cov_ff | window;

   gscc_line_chain u_line_chain (
      .clock    (clock),
      .ctrl     (chain_ctrl),
      .ins_data (ins_data),
      .tap_data (tap_data)
   );

   // A one-column grid reads back the entry that goes in this very cycle.
   assign up_data = (eff_width == gscc_pkg::EW_BITS'(1)) ? ins_data : tap_data;
   assign up_free = up_data.is_free;

   // Window test and the checks on cells that no later window can reach.
   always_comb begin
      free_now   = !req_blocked;
      col_nz     = (col != '0);
      at_end     = (col == last_col);
      window     = !first_row_ff && col_nz && free_now && pend_free_ff
                   && up_free && up_left_free_ff;
      up_cov_new = up_data.covered | window;
      fail_step  = !first_row_ff
                   && ((col_nz && up_left_free_ff && !(up_left_cov_ff | window))
                       || (at_end && up_free && !up_cov_new));
      failed_new = failed_ff | fail_step;

      // Track the rightmost uncovered free cell of the current row.
      left_uncov         = col_nz && pend_free_ff && !(pend_cov_ff | window);
      cur_last_valid_new = cur_last_valid_ff | left_uncov;
      cur_last_idx_new   = left_uncov ? (col - gscc_pkg::COL_BITS'(1)) : cur_last_idx_ff;
      here_uncov         = free_now && !window;

      // A frame that ends before its last column leaves part of the row above unjudged.
      tail_fail    = !first_row_ff && !at_end
                     && ((up_free && !up_cov_new)
                         || (prev_last_valid_ff && (prev_last_idx_ff > col)));
      verdict_fail = failed_new || cur_last_valid_new || here_uncov || tail_fail;
   end

   // Next frame state.
   always_comb begin
      column_in          = column_ff;
      first_row_in       = first_row_ff;
      failed_in          = failed_ff;
      pend_free_in       = pend_free_ff;
      pend_cov_in        = pend_cov_ff;
      up_left_free_in    = up_left_free_ff;
      up_left_cov_in     = up_left_cov_ff;
      cur_last_valid_in  = cur_last_valid_ff;
      cur_last_idx_in    = cur_last_idx_ff;
      prev_last_valid_in = prev_last_valid_ff;
      prev_last_idx_in   = prev_last_idx_ff;
      if (accept) begin
         pend_free_in    = free_now;
         pend_cov_in     = window;
         up_left_free_in = up_free;
         up_left_cov_in  = up_cov_new;
         if (req_last_in_frame) begin
            column_in         = '0;
            first_row_in      = 1'b1;
            failed_in         = 1'b0;
            cur_last_valid_in = 1'b0;
         end else if (at_end) begin
            column_in          = '0;
            first_row_in       = 1'b0;
            failed_in          = failed_new;
            cur_last_valid_in  = 1'b0;
            prev_last_valid_in = cur_last_valid_new | here_uncov;
            prev_last_idx_in   = here_uncov ? col : cur_last_idx_new;
         end else begin
            column_in         = col + gscc_pkg::COL_BITS'(1);
            failed_in         = failed_new;
            cur_last_valid_in = cur_last_valid_new;
            cur_last_idx_in   = cur_last_idx_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff          <= '0;
         first_row_ff       <= 1'b1;
         failed_ff          <= 1'b0;
         cur_last_valid_ff  <= 1'b0;
         prev_last_valid_ff <= 1'b0;
      end else begin
         column_ff          <= column_in;
         first_row_ff       <= first_row_in;
         failed_ff          <= failed_in;
         cur_last_valid_ff  <= cur_last_valid_in;
         prev_last_valid_ff <= prev_last_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_free_ff     <= pend_free_in;
      pend_cov_ff      <= pend_cov_in;
      up_left_free_ff  <= up_left_free_in;
      up_left_cov_ff   <= up_left_cov_in;
      cur_last_idx_ff  <= cur_last_idx_in;
      prev_last_idx_ff <= prev_last_idx_in;
   end

   // Verdict queue toward the response channel.
   gscc_rsp_queue u_rsp_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (accept && req_last_in_frame),
      .push_data       (!verdict_fail),
      .full            (queue_full),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_all_covered (rsp_all_covered)
   );

endmodule
